### rtl/hsfd_pkg.sv
// Package with the types, codes and arithmetic helpers of the sensor frame decoder.
package hsfd_pkg;

  localparam logic [7:0]  CRC_INIT = 8'hFF;
  localparam logic [7:0]  CRC_POLY = 8'h31;
  localparam logic [15:0] RAW_MASK = 16'hFFFC;
  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

  typedef logic signed [14:0] temp_t;
  typedef logic [13:0] hum_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_ERR = 2'd1,
    STATUS_HUM_ERR  = 2'd2
  } status_t;

  // CRC-8 over one byte, most significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Floor of x / 65535 for x below 65535 * 65535, done with shifts and adds.
  function automatic logic [15:0] div_65535(input logic [31:0] x);
    logic [32:0] s;
    s = {1'b0, x} + {17'd0, x[31:16]} + 33'd1;
    return s[31:16];
  endfunction

  function automatic temp_t scale_temp(input logic [15:0] raw);
    logic [30:0] prod;
    logic [15:0] q;
    logic signed [15:0] t;
    prod = {16'd0, TEMP_SCALE} * {15'd0, raw & RAW_MASK};
    q = div_65535({1'b0, prod});
    t = $signed(q) - TEMP_OFFSET;
    return t[14:0];
  endfunction

  function automatic hum_t scale_hum(input logic [15:0] raw);
    logic [29:0] prod;
    logic [15:0] q;
    prod = {16'd0, HUM_SCALE} * {14'd0, raw & RAW_MASK};
    q = div_65535({2'b0, prod});
    return q[13:0];
  endfunction

endpackage

### rtl/hsfd_if.sv
// Valid/ready channel interfaces for the received bytes and the decoded results.
interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  hsfd_pkg::temp_t    temperature_centi;
  hsfd_pkg::hum_t     humidity_centi;
  hsfd_pkg::status_t  frame_status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output frame_status, input ready);
  modport sink (input valid, input temperature_centi, input humidity_centi,
                input frame_status, output ready);
endinterface

### rtl/humidity_sensor_frame_decoder.sv
// Sensor reply decoder: CRC-8 check of two data words and scaling to centi units.
// A result is registered when the sixth byte of a reply leaves the input register.
// One byte per cycle unless stalled; CRC step and constant scaling are combinational.
// A byte waits in the input register only while a finished result is not yet taken.
// Reset (synchronous, active low) empties both registers and restarts at the first byte.
module humidity_sensor_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  hsfd_in_if.sink            in_ch,
  hsfd_out_if.source         out_ch
);
  import hsfd_pkg::*;

  typedef enum logic [2:0] {
    POS_TMSB = 3'd0,
    POS_TLSB = 3'd1,
    POS_TCRC = 3'd2,
    POS_HMSB = 3'd3,
    POS_HLSB = 3'd4,
    POS_HCRC = 3'd5
  } pos_t;

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        in_rdy;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] traw_r, traw_nxt;
  logic [15:0] hraw_r, hraw_nxt;
  logic        tok_r, tok_nxt;

  logic        emit;
  logic        adv;
  status_t     status_nxt;
  temp_t       temp_nxt;
  hum_t        hum_nxt;

  logic        out_vld_r;
  temp_t       temp_r;
  hum_t        hum_r;
  status_t     status_r;

  always_comb begin
    if (in_start_r) begin
      pos_eff = POS_TMSB;
    end else begin
      pos_eff = pos_r;
    end
  end

  assign emit   = (pos_eff == POS_HCRC);
  assign adv    = in_vld_r && (!emit || !out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || adv;

  always_comb begin
    crc_nxt  = crc_r;
    traw_nxt = traw_r;
    hraw_nxt = hraw_r;
    tok_nxt  = tok_r;
    pos_nxt  = POS_TMSB;
    unique case (pos_eff)
      POS_TLSB: begin
        crc_nxt  = crc8_update(crc_r, in_byte_r);
        traw_nxt = {traw_r[15:8], in_byte_r};
        pos_nxt  = POS_TCRC;
      end
      POS_TCRC: begin
        tok_nxt = (crc_r == in_byte_r);
        crc_nxt = CRC_INIT;
        pos_nxt = POS_HMSB;
      end
      POS_HMSB: begin
        crc_nxt  = crc8_update(CRC_INIT, in_byte_r);
        hraw_nxt = {in_byte_r, 8'd0};
        pos_nxt  = POS_HLSB;
      end
      POS_HLSB: begin
        crc_nxt  = crc8_update(crc_r, in_byte_r);
        hraw_nxt = {hraw_r[15:8], in_byte_r};
        pos_nxt  = POS_HCRC;
      end
      POS_HCRC: begin
        crc_nxt = CRC_INIT;
        pos_nxt = POS_TMSB;
      end
      default: begin
        // First byte of a reply; unused positions restart here as well.
        crc_nxt  = crc8_update(CRC_INIT, in_byte_r);
        traw_nxt = {in_byte_r, 8'd0};
        pos_nxt  = POS_TLSB;
      end
    endcase
  end

  always_comb begin
    temp_nxt = '0;
    hum_nxt  = '0;
    priority if (!tok_r) begin
      status_nxt = STATUS_TEMP_ERR;
    end else if (crc_r != in_byte_r) begin
      status_nxt = STATUS_HUM_ERR;
    end else begin
      status_nxt = STATUS_OK;
      temp_nxt   = scale_temp(traw_r);
      hum_nxt    = scale_hum(hraw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      pos_r     <= POS_TMSB;
      crc_r     <= CRC_INIT;
      traw_r    <= '0;
      hraw_r    <= '0;
      tok_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_r <= in_ch.valid;
        if (in_ch.valid) begin
          in_byte_r  <= in_ch.rx_byte;
          in_start_r <= in_ch.frame_start;
        end
      end
      if (adv) begin
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        traw_r <= traw_nxt;
        hraw_r <= hraw_nxt;
        tok_r  <= tok_nxt;
      end
      if (adv && emit) begin
        out_vld_r <= 1'b1;
        temp_r    <= temp_nxt;
        hum_r     <= hum_nxt;
        status_r  <= status_nxt;
      end else if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready              = in_rdy;
  assign out_ch.valid             = out_vld_r;
  assign out_ch.temperature_centi = temp_r;
  assign out_ch.humidity_centi    = hum_r;
  assign out_ch.frame_status      = status_r;

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r != STATUS_OK) |-> (temp_r == '0 && hum_r == '0))
    else $error("error result carries nonzero values");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && status_r == STATUS_OK) |->
      (hum_r <= 14'd9999 && temp_r >= -15'sd4500 && temp_r <= 15'sd12999))
    else $error("scaled value out of range");

  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv && emit))
    else $error("result loaded without a final byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rdy |-> (in_vld_r && emit && out_vld_r))
    else $error("input stalled without a waiting result");
`endif

endmodule

### tb/tb_humidity_sensor_frame_decoder.sv
// Self-checking testbench for the sensor reply decoder: CRC checks, scaling and flow control.
`timescale 1ns / 1ps

module tb_humidity_sensor_frame_decoder;
  import hsfd_pkg::*;

  localparam logic [7:0] SENSOR_CRC_SEED = 8'hFF;
  localparam logic [7:0] SENSOR_CRC_POLY = 8'h31;
  localparam int TARGET_BYTES = 1450;
  localparam int IDLE_PERCENT = 33;
  localparam int HOLD_AT_BYTE = 300;
  localparam int HOLD_CYCLES = 150;
  localparam int STEADY_FROM = 700;
  localparam int STEADY_TO = 900;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct {
    temp_t   temperature;
    hum_t    humidity;
    status_t status;
  } reading_t;

  logic clk;
  logic rst_n;

  hsfd_in_if in_ch ();
  hsfd_out_if out_ch ();

  humidity_sensor_frame_decoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rx_item_t pending_bytes[$];
  reading_t expected_readings[$];
  rx_item_t next_item;
  reading_t got_reading;
  reading_t want_reading;

  logic [2:0]  frame_pos = 3'd0;
  logic [7:0]  crc_acc = SENSOR_CRC_SEED;
  logic [15:0] temp_word = 16'h0000;
  logic [15:0] hum_word = 16'h0000;
  logic        temp_crc_good = 1'b0;

  int bytes_planned = 0;
  int bytes_sent = 0;
  int readings_seen = 0;
  int status_count[3] = '{0, 0, 0};
  int mismatches = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic steady;

  assign steady = (bytes_sent >= STEADY_FROM) && (bytes_sent < STEADY_TO);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? SENSOR_CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(SENSOR_CRC_SEED, w[15:8]), w[7:0]);
  endfunction

  function automatic temp_t centidegrees(input logic [15:0] raw);
    longint unsigned q;
    longint          c;
    q = (64'd17500 * {48'd0, raw & 16'hFFFC}) / 64'd65535;
    c = longint'(q) - 4500;
    return c[14:0];
  endfunction

  function automatic hum_t centipercent(input logic [15:0] raw);
    longint unsigned q;
    q = (64'd10000 * {48'd0, raw & 16'hFFFC}) / 64'd65535;
    return q[13:0];
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] corners[4];
    corners = '{16'h0000, 16'hFFFF, 16'hFFFC, 16'h0003};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 3)];
    end
    return 16'($urandom);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advances the decoder state by one accepted byte and records any reading it completes.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    reading_t r;
    if (start || frame_pos > 3'd5) begin
      frame_pos = 3'd0;
    end
    case (frame_pos)
      3'd0: begin
        crc_acc = crc8_step(SENSOR_CRC_SEED, b);
        temp_word = {b, 8'h00};
        frame_pos = 3'd1;
      end
      3'd1: begin
        crc_acc = crc8_step(crc_acc, b);
        temp_word[7:0] = b;
        frame_pos = 3'd2;
      end
      3'd2: begin
        temp_crc_good = (crc_acc == b);
        crc_acc = SENSOR_CRC_SEED;
        frame_pos = 3'd3;
      end
      3'd3: begin
        crc_acc = crc8_step(SENSOR_CRC_SEED, b);
        hum_word = {b, 8'h00};
        frame_pos = 3'd4;
      end
      3'd4: begin
        crc_acc = crc8_step(crc_acc, b);
        hum_word[7:0] = b;
        frame_pos = 3'd5;
      end
      default: begin
        r.temperature = '0;
        r.humidity = '0;
        if (!temp_crc_good) begin
          r.status = STATUS_TEMP_ERR;
        end else if (crc_acc != b) begin
          r.status = STATUS_HUM_ERR;
        end else begin
          r.status = STATUS_OK;
          r.temperature = centidegrees(temp_word);
          r.humidity = centipercent(hum_word);
        end
        crc_acc = SENSOR_CRC_SEED;
        frame_pos = 3'd0;
        expected_readings.push_back(r);
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_item_t it;
    it.rx_byte = b;
    it.frame_start = start;
    pending_bytes.push_back(it);
    bytes_planned++;
  endtask

  // Queues one six-byte reply; bit 0 of bad_crc spoils the temperature CRC, bit 1 the humidity.
  task automatic queue_reply(input logic [15:0] tw, input logic [15:0] hw,
                             input logic [1:0] bad_crc, input logic start);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = word_crc(tw) ^ (bad_crc[0] ? 8'($urandom_range(1, 255)) : 8'h00);
    hc = word_crc(hw) ^ (bad_crc[1] ? 8'($urandom_range(1, 255)) : 8'h00);
    queue_byte(tw[15:8], start);
    queue_byte(tw[7:0], 1'b0);
    queue_byte(tc, 1'b0);
    queue_byte(hw[15:8], 1'b0);
    queue_byte(hw[7:0], 1'b0);
    queue_byte(hc, 1'b0);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = 8'h00;
    in_ch.frame_start = 1'b0;
    out_ch.ready = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= 8'h00;
      in_ch.frame_start <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.rx_byte, in_ch.frame_start);
        bytes_sent <= bytes_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
          next_item = pending_bytes.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.rx_byte <= next_item.rx_byte;
          in_ch.frame_start <= next_item.frame_start;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver hold-off so the decoder fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && bytes_sent >= HOLD_AT_BYTE) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_reading.temperature = out_ch.temperature_centi;
        got_reading.humidity = out_ch.humidity_centi;
        got_reading.status = out_ch.frame_status;
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected reading: temp %0d hum %0d status %0d",
                                    got_reading.temperature, got_reading.humidity,
                                    got_reading.status));
        end else begin
          want_reading = expected_readings.pop_front();
          if (got_reading.temperature !== want_reading.temperature) begin
            report_mismatch($sformatf("reading %0d temperature_centi: got %0d, expected %0d",
                                      readings_seen, got_reading.temperature,
                                      want_reading.temperature));
          end
          if (got_reading.humidity !== want_reading.humidity) begin
            report_mismatch($sformatf("reading %0d humidity_centi: got %0d, expected %0d",
                                      readings_seen, got_reading.humidity,
                                      want_reading.humidity));
          end
          if (got_reading.status !== want_reading.status) begin
            report_mismatch($sformatf("reading %0d frame_status: got %0d, expected %0d",
                                      readings_seen, got_reading.status,
                                      want_reading.status));
          end
          status_count[want_reading.status]++;
        end
        readings_seen++;
      end
      out_ch.ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  initial begin
    logic       aligned;
    int         kind;
    int         n;
    logic [7:0] b;

    // Directed part: extreme words, back-to-back replies, a restart and each CRC outcome.
    queue_reply(16'h0000, 16'hFFFF, 2'b00, 1'b1);
    queue_reply(16'hFFFF, 16'h0003, 2'b00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_reply(16'h8000, 16'h7FFF, 2'b11, 1'b1);
    queue_reply(16'h6666, 16'hFFFC, 2'b10, 1'b0);

    aligned = 1'b1;
    while (bytes_planned < TARGET_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        queue_reply(random_word(), random_word(), 2'b00, aligned ? 1'($urandom_range(0, 1)) : 1'b1);
        aligned = 1'b1;
      end else if (kind < 87) begin
        queue_reply(random_word(), random_word(), 2'($urandom_range(1, 3)),
                    aligned ? 1'($urandom_range(0, 1)) : 1'b1);
        aligned = 1'b1;
      end else if (kind < 96) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          queue_byte(b, (i == 0) ? (aligned ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0);
        end
        aligned = 1'b0;
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        aligned = 1'b0;
      end
    end

    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes and %0d readings, with restarts, noise and a long output stall.",
             bytes_sent, readings_seen);
    $display("Readings by status: %0d ok, %0d temperature CRC error, %0d humidity CRC error.",
             status_count[STATUS_OK], status_count[STATUS_TEMP_ERR], status_count[STATUS_HUM_ERR]);
    if (mismatches == 0) begin
      $display("tb_humidity_sensor_frame_decoder: clean");
    end else begin
      $display("tb_humidity_sensor_frame_decoder: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d readings still expected.", expected_readings.size());
    $display("tb_humidity_sensor_frame_decoder: errors");
    $finish;
  end

endmodule
